### hw/rtl/tcpsu_pkg.sv
package tcpsu_pkg;

    // item actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // register offsets
    localparam logic [4:0] OFF_STATUS   = 5'd21;
    localparam int         NUM_CH_OFFS  = 8;

    // per-channel register slots (offset bits 1..0)
    localparam logic [1:0] SLOT_CTRL  = 2'd0;
    localparam logic [1:0] SLOT_SWEEP = 2'd1;
    localparam logic [1:0] SLOT_LO    = 2'd2;
    localparam logic [1:0] SLOT_HI    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MUTE_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MUTE_SECOND = 2'd1;

    // frame sequencer
    localparam logic [15:0] QUARTER_FRAME_CYCLES = 16'd3729;

    // silent below this period
    localparam logic [10:0] MIN_PERIOD = 11'd8;

    // length counter load values
    localparam logic [7:0] LEN_TABLE [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    // duty waveforms, bit i is sequencer step i
    localparam logic [7:0] DUTY_TABLE [4] = '{
        8'b0000_0010,
        8'b0000_0110,
        8'b0001_1110,
        8'b1111_1001
    };

    // controls from the top level to one channel
    typedef struct packed {
        logic       wr_ctrl;
        logic       wr_sweep;
        logic       wr_lo;
        logic       wr_hi;
        logic       clear_len;
        logic       tick;
        logic       quarter;
        logic       half;
        logic       en;
        logic       en_next;
        logic [7:0] data;
    } ch_ctl_t;

endpackage

### hw/rtl/tcpsu_pulse_ch.sv
module tcpsu_pulse_ch
    import tcpsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ch_ctl_t    ctl,
    input  logic       ones_comp,
    output logic [3:0] level_next
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  sweep_reg, sweep_next;
    logic [10:0] period_reg, period_next;
    logic [11:0] pcount_reg, pcount_next;
    logic [2:0]  duty_pos_reg, duty_pos_next;
    logic [7:0]  length_reg, length_next;
    logic        env_start_reg, env_start_next;
    logic [3:0]  decay_reg, decay_next;
    logic [3:0]  env_div_reg, env_div_next;
    logic [2:0]  sweep_div_reg, sweep_div_next;
    logic        sweep_reload_reg, sweep_reload_next;
    logic        duty_out_reg, duty_out_next;

    logic        active;
    logic        active_next;
    logic [10:0] delta;
    logic [10:0] target;
    logic [3:0]  volume_next;

    assign active = ctl.en && (length_reg != 8'd0) && (period_reg >= MIN_PERIOD);

    // sweep target from the live period
    assign delta  = period_reg >> sweep_reg[2:0];
    assign target = sweep_reg[3] ? (period_reg - delta - {10'd0, ones_comp})
                                 : (period_reg + delta);

    // next channel state for this item
    always_comb
    begin
        control_next      = control_reg;
        sweep_next        = sweep_reg;
        period_next       = period_reg;
        pcount_next       = pcount_reg;
        duty_pos_next     = duty_pos_reg;
        length_next       = length_reg;
        env_start_next    = env_start_reg;
        decay_next        = decay_reg;
        env_div_next      = env_div_reg;
        sweep_div_next    = sweep_div_reg;
        sweep_reload_next = sweep_reload_reg;
        duty_out_next     = duty_out_reg;

        // register writes
        if (ctl.wr_ctrl)
        begin
            control_next = ctl.data;
        end
        if (ctl.wr_sweep)
        begin
            sweep_next        = ctl.data;
            sweep_reload_next = 1'b1;
        end
        if (ctl.wr_lo)
        begin
            period_next = {period_reg[10:8], ctl.data};
            pcount_next = {1'b0, period_reg[10:8], ctl.data};
        end
        if (ctl.wr_hi)
        begin
            period_next    = {ctl.data[2:0], period_reg[7:0]};
            pcount_next    = {1'b0, ctl.data[2:0], period_reg[7:0]};
            duty_pos_next  = 3'd0;
            env_start_next = 1'b1;
            if (ctl.en)
            begin
                length_next = LEN_TABLE[ctl.data[7:3]];
            end
        end
        if (ctl.clear_len)
        begin
            length_next = 8'd0;
        end

        // timer and duty sequencer
        if (ctl.tick && active)
        begin
            if (pcount_reg == 12'd0)
            begin
                pcount_next   = {1'b0, period_reg} + 12'd1;
                duty_pos_next = duty_pos_reg + 3'd1;
                duty_out_next = DUTY_TABLE[control_reg[7:6]][duty_pos_next];
            end
            else
            begin
                pcount_next = pcount_reg - 12'd1;
            end
        end

        // envelope on every quarter frame
        if (ctl.quarter)
        begin
            if (env_start_reg)
            begin
                env_start_next = 1'b0;
                decay_next     = 4'd15;
                env_div_next   = control_reg[3:0];
            end
            else if (env_div_reg == 4'd0)
            begin
                env_div_next = control_reg[3:0];
                if (decay_reg != 4'd0)
                begin
                    decay_next = decay_reg - 4'd1;
                end
                else if (control_reg[5])
                begin
                    decay_next = 4'd15;
                end
            end
            else
            begin
                env_div_next = env_div_reg - 4'd1;
            end
        end

        // length counter and sweep on half frames
        if (ctl.half)
        begin
            if (!control_reg[5] && (length_reg != 8'd0))
            begin
                length_next = length_reg - 8'd1;
            end
            if ((sweep_div_reg == 3'd0) && sweep_reg[7] && (sweep_reg[2:0] != 3'd0))
            begin
                period_next = target;
            end
            if ((sweep_div_reg == 3'd0) || sweep_reload_reg)
            begin
                sweep_div_next    = sweep_reg[6:4];
                sweep_reload_next = 1'b0;
            end
            else
            begin
                sweep_div_next = sweep_div_reg - 3'd1;
            end
        end
    end

    // level after this item
    assign active_next = ctl.en_next && (length_next != 8'd0) && (period_next >= MIN_PERIOD);
    assign volume_next = control_next[4] ? control_next[3:0] : decay_next;
    assign level_next  = (active_next && duty_out_next) ? volume_next : 4'd0;

    // channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg      <= '0;
            sweep_reg        <= '0;
            period_reg       <= '0;
            pcount_reg       <= '0;
            duty_pos_reg     <= '0;
            length_reg       <= '0;
            env_start_reg    <= 1'b0;
            decay_reg        <= '0;
            env_div_reg      <= '0;
            sweep_div_reg    <= '0;
            sweep_reload_reg <= 1'b0;
            duty_out_reg     <= 1'b0;
        end
        else
        begin
            control_reg      <= control_next;
            sweep_reg        <= sweep_next;
            period_reg       <= period_next;
            pcount_reg       <= pcount_next;
            duty_pos_reg     <= duty_pos_next;
            length_reg       <= length_next;
            env_start_reg    <= env_start_next;
            decay_reg        <= decay_next;
            env_div_reg      <= env_div_next;
            sweep_div_reg    <= sweep_div_next;
            sweep_reload_reg <= sweep_reload_next;
            duty_out_reg     <= duty_out_next;
        end
    end

endmodule

### hw/rtl/two_channel_pulse_sound_unit_top.sv
// channel   direction  handshake                  payload
// item      into       item_valid / item_ready    action, reg_offset, write_data
// result    out of     result_valid / result_ready read_data, first_level,
//                                                 second_level, mixed_level
// cfg       into       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle while item_ready is high; each item's result is registered.
// Each transferred item updates the channel state in that same cycle.
// A two-deep output stage (result register plus skid register) takes one more item
// while the result side stalls; item_ready is low while the skid register is full,
// which includes the cycle in which it drains into the result register.
// Reset puts both channels silent and the frame countdown at a full quarter frame.
module two_channel_pulse_sound_unit_top
    import tcpsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] action,
    input  logic [4:0] reg_offset,
    input  logic [7:0] write_data,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] read_data,
    output logic [3:0] first_level,
    output logic [3:0] second_level,
    output logic [4:0] mixed_level,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic        accept;
    logic        is_write;
    logic        is_tick;
    logic        status_write;
    logic [4:0]  status_reg, status_next;
    logic [15:0] quarter_cnt_reg, quarter_cnt_next;
    logic [1:0]  frame_step_reg, frame_step_next;
    logic        quarter;
    logic        half;
    logic        mute_first_reg;
    logic        mute_second_reg;
    ch_ctl_t     ctl_a;
    ch_ctl_t     ctl_b;
    logic [3:0]  lvl_a;
    logic [3:0]  lvl_b;
    logic [7:0]  rd_value;
    logic [4:0]  mix_value;

    logic        result_valid_reg;
    logic [7:0]  read_data_reg;
    logic [3:0]  first_level_reg;
    logic [3:0]  second_level_reg;
    logic [4:0]  mixed_level_reg;
    logic        skid_valid_reg;
    logic [7:0]  skid_read_reg;
    logic [3:0]  skid_first_reg;
    logic [3:0]  skid_second_reg;
    logic [4:0]  skid_mixed_reg;

    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign is_write   = accept && (action == ACT_WRITE);
    assign is_tick    = accept && (action == ACT_TICK);
    assign status_write = is_write && (reg_offset == OFF_STATUS);

    // status bits
    assign status_next = status_write ? write_data[4:0] : status_reg;

    // frame sequencer
    always_comb
    begin
        quarter_cnt_next = quarter_cnt_reg;
        frame_step_next  = frame_step_reg;
        quarter          = 1'b0;
        if (is_tick)
        begin
            if (quarter_cnt_reg == 16'd1)
            begin
                quarter          = 1'b1;
                quarter_cnt_next = QUARTER_FRAME_CYCLES;
                frame_step_next  = frame_step_reg + 2'd1;
            end
            else
            begin
                quarter_cnt_next = quarter_cnt_reg - 16'd1;
            end
        end
    end
    assign half = quarter && frame_step_reg[0];

    // per-channel controls
    always_comb
    begin
        ctl_a           = '0;
        ctl_a.data      = write_data;
        ctl_a.tick      = is_tick;
        ctl_a.quarter   = quarter;
        ctl_a.half      = half;
        ctl_a.en        = status_reg[0];
        ctl_a.en_next   = status_next[0];
        ctl_a.clear_len = status_write && !status_next[0];
        ctl_b           = ctl_a;
        ctl_b.en        = status_reg[1];
        ctl_b.en_next   = status_next[1];
        ctl_b.clear_len = status_write && !status_next[1];
        if (is_write && ({27'd0, reg_offset} < NUM_CH_OFFS))
        begin
            if (!reg_offset[2])
            begin
                ctl_a.wr_ctrl  = (reg_offset[1:0] == SLOT_CTRL);
                ctl_a.wr_sweep = (reg_offset[1:0] == SLOT_SWEEP);
                ctl_a.wr_lo    = (reg_offset[1:0] == SLOT_LO);
                ctl_a.wr_hi    = (reg_offset[1:0] == SLOT_HI);
            end
            else
            begin
                ctl_b.wr_ctrl  = (reg_offset[1:0] == SLOT_CTRL);
                ctl_b.wr_sweep = (reg_offset[1:0] == SLOT_SWEEP);
                ctl_b.wr_lo    = (reg_offset[1:0] == SLOT_LO);
                ctl_b.wr_hi    = (reg_offset[1:0] == SLOT_HI);
            end
        end
    end

    tcpsu_pulse_ch u_pulse_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_a),
        .ones_comp  (1'b1),
        .level_next (lvl_a)
    );

    tcpsu_pulse_ch u_pulse_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_b),
        .ones_comp  (1'b0),
        .level_next (lvl_b)
    );

    // result values
    assign rd_value  = ((action == ACT_READ) && (reg_offset == OFF_STATUS))
                       ? {3'd0, status_reg} : 8'd0;
    assign mix_value = (mute_first_reg ? 5'd0 : {1'b0, lvl_a})
                     + (mute_second_reg ? 5'd0 : {1'b0, lvl_b});

    // unit state and configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= '0;
            quarter_cnt_reg <= QUARTER_FRAME_CYCLES;
            frame_step_reg  <= '0;
            mute_first_reg  <= 1'b0;
            mute_second_reg <= 1'b0;
        end
        else
        begin
            status_reg      <= status_next;
            quarter_cnt_reg <= quarter_cnt_next;
            frame_step_reg  <= frame_step_next;
            if (cfg_valid && (cfg_index == CFG_MUTE_FIRST))
            begin
                mute_first_reg <= cfg_data[0];
            end
            if (cfg_valid && (cfg_index == CFG_MUTE_SECOND))
            begin
                mute_second_reg <= cfg_data[0];
            end
        end
    end

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (result_valid_reg && !result_ready)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            result_valid_reg <= 1'b1;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            result_valid_reg <= accept;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (result_valid_reg && !result_ready)
        begin
            if (accept)
            begin
                skid_read_reg   <= rd_value;
                skid_first_reg  <= lvl_a;
                skid_second_reg <= lvl_b;
                skid_mixed_reg  <= mix_value;
            end
        end
        else if (skid_valid_reg)
        begin
            read_data_reg    <= skid_read_reg;
            first_level_reg  <= skid_first_reg;
            second_level_reg <= skid_second_reg;
            mixed_level_reg  <= skid_mixed_reg;
        end
        else if (accept)
        begin
            read_data_reg    <= rd_value;
            first_level_reg  <= lvl_a;
            second_level_reg <= lvl_b;
            mixed_level_reg  <= mix_value;
        end
    end

    assign result_valid = result_valid_reg;
    assign read_data    = read_data_reg;
    assign first_level  = first_level_reg;
    assign second_level = second_level_reg;
    assign mixed_level  = mixed_level_reg;

    // checks
    a_skid_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid holds a result while result register is empty");

    a_countdown_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        quarter_cnt_reg != 16'd0)
        else $error("quarter frame countdown reached zero");

    a_status_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (read_data_reg[7:5] == 3'd0))
        else $error("status read carries bits above the five status flags");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready && accept) |=> skid_valid_reg)
        else $error("item taken during a stall was not held in the skid register");

endmodule

### tb/tb_top.sv
module tb_top;
    import tcpsu_pkg::*;

    // codes the package leaves out
    localparam logic [1:0] ACT_SPARE     = 2'd3;
    localparam logic [1:0] CFG_SPARE_LO  = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI  = 2'd3;
    localparam logic [4:0] OFF_FRAME_CTR = 5'd23;
    localparam logic [4:0] OFF_NOISE_LO  = 5'd12;

    localparam int QUIET_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 400;
    localparam int FRAME_ROUNDS  = 2;

    // length counter load values, indexed by the top five bits of the fourth byte
    localparam logic [7:0] LENGTH_LOAD [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    // square waveforms, bit n is sequencer position n
    localparam logic [7:0] DUTY_WAVE [4] = '{
        8'b0000_0010,
        8'b0000_0110,
        8'b0001_1110,
        8'b1111_1001
    };

    typedef struct packed {
        logic [7:0]  ctrl;
        logic [7:0]  sweep;
        logic [10:0] period;
        logic [11:0] timer;
        logic [2:0]  seq_pos;
        logic [7:0]  len_count;
        logic        env_start;
        logic [3:0]  decay;
        logic [3:0]  env_div;
        logic [2:0]  sweep_div;
        logic        sweep_reload;
        logic        duty_bit;
    } pulse_t;

    typedef struct packed {
        logic [7:0] rd;
        logic [3:0] l1;
        logic [3:0] l2;
        logic [4:0] mix;
    } levels_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [1:0] action;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] read_data;
    logic [3:0] first_level;
    logic [3:0] second_level;
    logic [4:0] mixed_level;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // predicted sound unit state
    pulse_t      chan_m [2];
    logic [4:0]  enable_m;
    logic [1:0]  frame_step_m;
    logic [15:0] quarter_left_m;
    logic        mute_m [2];

    levels_t levels_due_q [$];

    int  items_sent;
    int  results_checked = 0;
    int  mismatches = 0;
    int  quarter_frames;
    int  quiet_cycles = 0;
    bit  source_calm;
    bit  sink_calm;
    int  hold_requests;
    int  hold_served = 0;
    int  sink_hold_left = 0;
    int  sink_stall_left = 0;

    two_channel_pulse_sound_unit_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .reg_offset   (reg_offset),
        .write_data   (write_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .read_data    (read_data),
        .first_level  (first_level),
        .second_level (second_level),
        .mixed_level  (mixed_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------

    function automatic void clear_prediction();
        for (int k = 0; k < 2; k++)
        begin
            chan_m[k] = '0;
            mute_m[k] = 1'b0;
        end
        enable_m       = '0;
        frame_step_m   = '0;
        quarter_left_m = QUARTER_FRAME_CYCLES;
    endfunction

    function automatic bit channel_running(int k);
        return enable_m[k] && chan_m[k].len_count != 8'd0 && chan_m[k].period >= MIN_PERIOD;
    endfunction

    function automatic logic [3:0] channel_level(int k);
        if (!channel_running(k) || !chan_m[k].duty_bit)
            return 4'd0;
        return chan_m[k].ctrl[4] ? chan_m[k].ctrl[3:0] : chan_m[k].decay;
    endfunction

    function automatic void clock_envelope(int k);
        if (chan_m[k].env_start)
        begin
            chan_m[k].env_start = 1'b0;
            chan_m[k].decay     = 4'd15;
            chan_m[k].env_div   = chan_m[k].ctrl[3:0];
        end
        else if (chan_m[k].env_div == 4'd0)
        begin
            chan_m[k].env_div = chan_m[k].ctrl[3:0];
            if (chan_m[k].decay != 4'd0)
                chan_m[k].decay = chan_m[k].decay - 4'd1;
            else if (chan_m[k].ctrl[5])
                chan_m[k].decay = 4'd15;
        end
        else
        begin
            chan_m[k].env_div = chan_m[k].env_div - 4'd1;
        end
    endfunction

    // first channel negates with one's complement, second with two's
    function automatic void clock_sweep(int k);
        logic [11:0] delta;
        logic [11:0] target;
        logic [2:0]  shift;
        shift = chan_m[k].sweep[2:0];
        if (chan_m[k].sweep_div == 3'd0 && chan_m[k].sweep[7] && shift != 3'd0)
        begin
            delta = {1'b0, chan_m[k].period} >> shift;
            if (chan_m[k].sweep[3])
                target = {1'b0, chan_m[k].period} - delta - ((k == 0) ? 12'd1 : 12'd0);
            else
                target = {1'b0, chan_m[k].period} + delta;
            chan_m[k].period = target[10:0];
        end
        if (chan_m[k].sweep_div == 3'd0 || chan_m[k].sweep_reload)
        begin
            chan_m[k].sweep_div    = chan_m[k].sweep[6:4];
            chan_m[k].sweep_reload = 1'b0;
        end
        else
        begin
            chan_m[k].sweep_div = chan_m[k].sweep_div - 3'd1;
        end
    endfunction

    // quarter frame: envelopes, and on half frames lengths and sweeps
    function automatic void clock_frame();
        quarter_frames++;
        for (int k = 0; k < 2; k++)
            clock_envelope(k);
        if (frame_step_m == 2'd1 || frame_step_m == 2'd3)
        begin
            for (int k = 0; k < 2; k++)
                if (!chan_m[k].ctrl[5] && chan_m[k].len_count != 8'd0)
                    chan_m[k].len_count = chan_m[k].len_count - 8'd1;
            clock_sweep(0);
            clock_sweep(1);
        end
        frame_step_m = frame_step_m + 2'd1;
    endfunction

    function automatic void advance_clock();
        for (int k = 0; k < 2; k++)
        begin
            if (channel_running(k))
            begin
                if (chan_m[k].timer == 12'd0)
                begin
                    chan_m[k].timer    = {1'b0, chan_m[k].period} + 12'd1;
                    chan_m[k].seq_pos  = chan_m[k].seq_pos + 3'd1;
                    chan_m[k].duty_bit = DUTY_WAVE[chan_m[k].ctrl[7:6]][chan_m[k].seq_pos];
                end
                else
                begin
                    chan_m[k].timer = chan_m[k].timer - 12'd1;
                end
            end
        end
        quarter_left_m = quarter_left_m - 16'd1;
        if (quarter_left_m == 16'd0)
        begin
            clock_frame();
            quarter_left_m = QUARTER_FRAME_CYCLES;
        end
    endfunction

    function automatic void write_register(logic [4:0] off, logic [7:0] dat);
        int k;
        k = off[2];
        if (off == OFF_STATUS)
        begin
            enable_m = dat[4:0];
            for (int j = 0; j < 2; j++)
                if (!enable_m[j])
                    chan_m[j].len_count = 8'd0;
        end
        else if (off < NUM_CH_OFFS)
        begin
            case (off[1:0])
                SLOT_CTRL:
                    chan_m[k].ctrl = dat;
                SLOT_SWEEP:
                begin
                    chan_m[k].sweep        = dat;
                    chan_m[k].sweep_reload = 1'b1;
                end
                SLOT_LO:
                begin
                    chan_m[k].period[7:0] = dat;
                    chan_m[k].timer       = {1'b0, chan_m[k].period};
                end
                SLOT_HI:
                begin
                    chan_m[k].period[10:8] = dat[2:0];
                    chan_m[k].timer        = {1'b0, chan_m[k].period};
                    if (enable_m[k])
                        chan_m[k].len_count = LENGTH_LOAD[dat[7:3]];
                    chan_m[k].seq_pos   = 3'd0;
                    chan_m[k].env_start = 1'b1;
                end
                default: ;
            endcase
        end
    endfunction

    function automatic levels_t predict_levels(logic [1:0] act, logic [4:0] off, logic [7:0] dat);
        levels_t r;
        r = '0;
        case (act)
            ACT_WRITE: write_register(off, dat);
            ACT_READ:  if (off == OFF_STATUS) r.rd = {3'b000, enable_m};
            ACT_TICK:  advance_clock();
            default:   ;
        endcase
        r.l1  = channel_level(0);
        r.l2  = channel_level(1);
        r.mix = (mute_m[0] ? 5'd0 : {1'b0, r.l1}) + (mute_m[1] ? 5'd0 : {1'b0, r.l2});
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------------

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [4:0] chan_offset(int k, logic [1:0] slot);
        return {2'b00, k[0], slot};
    endfunction

    // one item transfer, with its expected result queued at the transfer edge
    task automatic send_item(input logic [1:0] act, input logic [4:0] off, input logic [7:0] dat);
        int gap;
        @(negedge clk);
        item_valid <= 1'b1;
        action     <= act;
        reg_offset <= off;
        write_data <= dat;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        levels_due_q.push_back(predict_levels(act, off, dat));
        items_sent++;
        gap = (source_calm || $urandom_range(0, 3) != 0) ? 0 : idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // stop offering items and let every expected result come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (levels_due_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_mute(input logic [1:0] idx, input logic [7:0] val);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_MUTE_FIRST)
            mute_m[0] = val[0];
        else if (idx == CFG_MUTE_SECOND)
            mute_m[1] = val[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_channel(input int k, input logic [7:0] ctl, input logic [7:0] swp,
                                   input logic [10:0] per, input logic [4:0] len_idx);
        send_item(ACT_WRITE, chan_offset(k, SLOT_CTRL), ctl);
        send_item(ACT_WRITE, chan_offset(k, SLOT_SWEEP), swp);
        send_item(ACT_WRITE, chan_offset(k, SLOT_LO), per[7:0]);
        send_item(ACT_WRITE, chan_offset(k, SLOT_HI), {len_idx, per[10:8]});
    endtask

    task automatic program_random_channel(input int k);
        logic [10:0] per;
        case ($urandom_range(0, 5))
            0:       per = 11'($urandom_range(0, 7));
            1:       per = 11'($urandom);
            default: per = 11'($urandom_range(8, 48));
        endcase
        program_channel(k, 8'($urandom), 8'($urandom), per, 5'($urandom));
    endtask

    task automatic send_ticks(input int n);
        for (int t = 0; t < n; t++)
            send_item(ACT_TICK, 5'($urandom_range(0, 23)), 8'($urandom));
    endtask

    task automatic send_noise(input int n);
        for (int t = 0; t < n; t++)
            send_item(2'($urandom), 5'($urandom_range(0, 23)), 8'($urandom));
    endtask

    // ---------------------------------------------------------------------
    // result side: stalls, hold-off, checking, watchdog
    // ---------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served    = hold_requests;
            sink_hold_left = HOLD_CYCLES;
        end
        if (sink_hold_left > 0)
        begin
            result_ready <= 1'b0;
            sink_hold_left--;
        end
        else if (sink_stall_left > 0)
        begin
            result_ready <= 1'b0;
            sink_stall_left--;
        end
        else if (!sink_calm && $urandom_range(0, 5) == 0)
        begin
            result_ready    <= 1'b0;
            sink_stall_left = idle_length() - 1;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // compare each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        levels_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (levels_due_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: read_data %0d levels %0d %0d mix %0d",
                             read_data, first_level, second_level, mixed_level);
                mismatches++;
            end
            else
            begin
                want = levels_due_q.pop_front();
                if (read_data !== want.rd || first_level !== want.l1 ||
                    second_level !== want.l2 || mixed_level !== want.mix)
                begin
                    if (mismatches < 10)
                        $display("mismatch at result %0d: exp rd %0d l1 %0d l2 %0d mix %0d,",
                                 results_checked, want.rd, want.l1, want.l2, want.mix,
                                 " got rd %0d l1 %0d l2 %0d mix %0d",
                                 read_data, first_level, second_level, mixed_level);
                    mismatches++;
                end
            end
        end
    end

    // end the run if no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("two_channel_pulse_sound_unit_top verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------

    // reads, spare action, status masking, silent cases, first duty edge
    task automatic test_directed();
        source_calm = 1'b0;
        sink_calm   = 1'b0;
        send_item(ACT_READ, OFF_STATUS, 8'h00);
        send_item(ACT_SPARE, 5'($urandom_range(0, 23)), 8'hFF);
        send_item(ACT_READ, 5'd0, 8'hFF);
        // length load while disabled leaves the count at zero
        send_item(ACT_WRITE, chan_offset(0, SLOT_HI), 8'hFF);
        send_item(ACT_WRITE, OFF_STATUS, 8'hFF);
        send_item(ACT_READ, OFF_STATUS, 8'h00);
        send_item(ACT_WRITE, chan_offset(0, SLOT_CTRL), 8'hFF);
        send_item(ACT_WRITE, chan_offset(0, SLOT_LO), 8'h00);
        // period zero: length loads but the channel stays silent
        send_item(ACT_WRITE, chan_offset(0, SLOT_HI), 8'h00);
        send_item(ACT_TICK, 5'd0, 8'h00);
        send_item(ACT_WRITE, chan_offset(0, SLOT_LO), 8'h08);
        send_ticks(10);
        // writes to offsets outside the pulse channels are ignored
        send_item(ACT_WRITE, OFF_FRAME_CTR, 8'hFF);
        send_item(ACT_WRITE, OFF_NOISE_LO, 8'h5A);
        // disabling clears the length count
        send_item(ACT_WRITE, OFF_STATUS, 8'h00);
        send_item(ACT_TICK, OFF_FRAME_CTR, 8'hFF);
    endtask

    // every mute combination, plus the unused register indexes
    task automatic test_mute_settings();
        logic [1:0] combo;
        for (int c = 0; c < 4; c++)
        begin
            combo = 2'(c);
            write_mute(CFG_MUTE_FIRST, {7'($urandom), combo[0]});
            write_mute(CFG_MUTE_SECOND, {7'($urandom), combo[1]});
            write_mute(CFG_SPARE_LO, 8'($urandom));
            write_mute(CFG_SPARE_HI, 8'hFF);
            send_item(ACT_WRITE, OFF_STATUS, 8'h03);
            program_channel(0, 8'h9F, 8'h00, 11'(8 + c), 5'd1);
            program_channel(1, 8'hBA, 8'h00, 11'(9 + c), 5'd1);
            send_ticks(20);
        end
        write_mute(CFG_MUTE_FIRST, 8'h00);
        write_mute(CFG_MUTE_SECOND, 8'h00);
    endtask

    // receiver holds off long enough for the output stage to fill
    task automatic test_result_backpressure();
        source_calm = 1'b1;
        send_item(ACT_WRITE, OFF_STATUS, 8'h03);
        program_channel(0, 8'h5C, 8'h00, 11'd10, 5'd3);
        hold_requests++;
        send_ticks(30);
        send_item(ACT_READ, OFF_STATUS, 8'h00);
        source_calm = 1'b0;
    endtask

    // mostly well-formed programming followed by ticks, some noise and partial setups
    task automatic test_random_traffic();
        int start;
        logic [7:0] d;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            source_calm = ($urandom_range(0, 4) == 0);
            sink_calm   = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        d = 8'($urandom);
                        if ($urandom_range(0, 3) != 0)
                            d[1:0] = 2'b11;
                        send_item(ACT_WRITE, OFF_STATUS, d);
                    end
                    program_random_channel($urandom_range(0, 1));
                    if ($urandom_range(0, 1) == 0)
                        program_random_channel($urandom_range(0, 1));
                    send_ticks($urandom_range(10, 60));
                    send_item(ACT_READ, OFF_STATUS, 8'($urandom));
                end
                6, 7:
                    send_noise(12);
                default:
                begin
                    send_item(ACT_WRITE, chan_offset($urandom_range(0, 1), 2'($urandom)),
                              8'($urandom));
                    send_ticks($urandom_range(2, 20));
                end
            endcase
        end
        source_calm = 1'b0;
        sink_calm   = 1'b0;
    endtask

    // tick runs on freshly programmed envelopes and sweeps, rare writes and reads mixed in
    task automatic test_frame_sequencer();
        int n;
        logic [7:0] ctl;
        logic [7:0] swp;
        for (int r = 0; r < FRAME_ROUNDS; r++)
        begin
            write_mute(CFG_MUTE_FIRST, 8'($urandom));
            write_mute(CFG_MUTE_SECOND, 8'($urandom));
            send_item(ACT_WRITE, OFF_STATUS, {3'($urandom), 3'($urandom), 2'b11});
            for (int k = 0; k < 2; k++)
            begin
                ctl = {2'($urandom), 1'($urandom), ($urandom_range(0, 3) == 0),
                       4'($urandom_range(0, 2))};
                swp = {($urandom_range(0, 4) != 0), 3'($urandom_range(0, 2)), 1'($urandom),
                       3'($urandom)};
                program_channel(k, ctl, swp, 11'($urandom_range(8, 600)),
                                ($urandom_range(0, 1) == 0) ? 5'd3 : 5'($urandom));
            end
            source_calm = ($urandom_range(0, 2) != 0);
            sink_calm   = ($urandom_range(0, 2) == 0);
            n = $urandom_range(50, 70);
            for (int t = 0; t < n; t++)
            begin
                if ($urandom_range(0, 599) == 0)
                    send_item(ACT_WRITE, chan_offset($urandom_range(0, 1), 2'($urandom)),
                              8'($urandom));
                else if ($urandom_range(0, 599) == 0)
                    send_item(ACT_READ, OFF_STATUS, 8'($urandom));
                else
                    send_item(ACT_TICK, 5'($urandom_range(0, 23)), 8'($urandom));
            end
        end
        source_calm = 1'b0;
        sink_calm   = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        item_valid      = 1'b0;
        action          = ACT_WRITE;
        reg_offset      = '0;
        write_data      = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_MUTE_FIRST;
        cfg_data        = '0;
        items_sent      = 0;
        quarter_frames  = 0;
        source_calm     = 1'b0;
        sink_calm       = 1'b0;
        hold_requests   = 0;
        clear_prediction();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_mute_settings();
        test_result_backpressure();
        test_random_traffic();
        test_frame_sequencer();

        source_calm = 1'b1;
        sink_calm   = 1'b1;
        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d items and %0d results over %0d quarter frames, all mute settings",
                 items_sent, results_checked, quarter_frames);
        $display("mismatching results: %0d", mismatches);
        if (mismatches == 0 && levels_due_q.size() == 0)
            $display("two_channel_pulse_sound_unit_top verification clean");
        else
            $display("two_channel_pulse_sound_unit_top verification failed");
        $finish;
    end

endmodule
